// ----- design/text_console_cursor_scroll_defines.svh -----
// assertion macros for the console engine modules
// no dependencies; included by files that carry assertions
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define TCCS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: %m");

// antecedent implies consequent in the same cycle
`define TCCS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// antecedent implies consequent in the next cycle
`define TCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`else

`define TCCS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TCCS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/tccs_pkg.sv -----
// types and constants of the text console engine
// no dependencies
package tccs_pkg;

	localparam logic [2:0] CMD_APPEND = 3'd0;
	localparam logic [2:0] CMD_CLEAR  = 3'd1;
	localparam logic [2:0] CMD_WRITE  = 3'd2;
	localparam logic [2:0] CMD_SET    = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'd7;

	localparam int POS_W  = 11;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	typedef struct packed {
		logic [POS_W-1:0]  cursor;
		logic [CHAR_W-1:0] cell_char;
		logic [CHAR_W-1:0] cell_color;
		logic              scrolled;
	} res_t;

endpackage

// ----- design/tccs_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module tccs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/tccs_ctrl.sv -----
// command sequencer with the shared address stepper of the console engine
// depends on tccs_pkg and text_console_cursor_scroll_defines.svh
`include "text_console_cursor_scroll_defines.svh"

module tccs_ctrl #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [2:0]                             command,
	input  logic [tccs_pkg::CHAR_W-1:0]            char_code,
	input  logic [tccs_pkg::CHAR_W-1:0]            color,
	input  logic [tccs_pkg::POS_W-1:0]             position,
	input  logic [tccs_pkg::CHAR_W-1:0]            blank_color,
	output logic                                   ram_we,
	output logic [$clog2(COLUMNS*ROWS)-1:0]        ram_waddr,
	output logic [tccs_pkg::CELL_W-1:0]            ram_wdata,
	output logic [$clog2(COLUMNS*ROWS)-1:0]        ram_raddr,
	input  logic [tccs_pkg::CELL_W-1:0]            ram_rdata,
	output logic                                   res_valid,
	input  logic                                   res_take,
	output tccs_pkg::res_t                         res
);

	import tccs_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int IW    = AW + 1;
	localparam int PW    = (AW > POS_W) ? AW : POS_W;
	localparam int LAST  = CELLS - 1;
	localparam int LRS   = (ROWS - 1) * COLUMNS;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_FILL  = 3'd2;
	localparam logic [2:0] S_ROWF  = 3'd3;
	localparam logic [2:0] S_COPY  = 3'd4;
	localparam logic [2:0] S_BLANK = 3'd5;
	localparam logic [2:0] S_READ  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]        state_q;
	logic [IW-1:0]     idx_q;
	logic [AW-1:0]     wa_q;
	logic [AW-1:0]     cursor_q;
	logic              rd_pend_q;
	logic              scr_q;
	logic [CHAR_W-1:0] rd_chr_q;
	logic [CHAR_W-1:0] rd_col_q;

	logic              accept;
	logic [PW-1:0]     pos_ext;
	logic [AW-1:0]     pos_c;
	logic [IW-1:0]     incr;
	logic [IW-1:0]     sum;
	logic              row_found;
	logic [PW-1:0]     cur_ext;
	logic [CHAR_W-1:0] fill_col;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_ready = (state_q == S_IDLE);

	// clamp the requested position to the last cell
	assign pos_ext = PW'(position);
	assign pos_c   = (pos_ext > PW'(LAST)) ? AW'(LAST) : pos_ext[AW-1:0];

	// shared stepper: one cell, or one row while searching the cursor row
	assign incr      = (state_q == S_ROWF) ? IW'(COLUMNS) : IW'(1);
	assign sum       = idx_q + incr;
	assign row_found = IW'(cursor_q) < sum;

	assign fill_col = (state_q == S_INIT) ? RESET_COLOR : blank_color;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = {fill_col, BLANK_CHAR};
		case (state_q)
			S_INIT, S_FILL: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				ram_wdata = {color, char_code};
				if (command == CMD_APPEND) begin
					ram_waddr = cursor_q;
					ram_we    = accept && (char_code != NEWLINE_CHAR);
				end else begin
					ram_waddr = pos_c;
					ram_we    = accept && (command == CMD_WRITE);
				end
			end
			S_COPY: begin
				ram_we    = rd_pend_q;
				ram_waddr = wa_q;
				ram_wdata = ram_rdata;
			end
			S_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = wa_q;
				ram_wdata = rd_pend_q ? ram_rdata : {blank_color, BLANK_CHAR};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_raddr = (state_q == S_IDLE) ? pos_c : idx_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			idx_q     <= '0;
			wa_q      <= '0;
			cursor_q  <= '0;
			rd_pend_q <= 1'b0;
			scr_q     <= 1'b0;
			rd_chr_q  <= '0;
			rd_col_q  <= '0;
		end else begin
			rd_pend_q <= (state_q == S_COPY);
			if (ram_we && (state_q == S_COPY || state_q == S_BLANK)) begin
				wa_q <= wa_q + 1'b1;
			end
			case (state_q)
				S_INIT: begin
					idx_q <= sum;
					if (idx_q == IW'(LAST)) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rd_chr_q <= '0;
						rd_col_q <= '0;
						scr_q    <= 1'b0;
						idx_q    <= '0;
						case (command)
							CMD_APPEND: begin
								if (char_code == NEWLINE_CHAR) begin
									state_q <= S_ROWF;
								end else if (cursor_q == AW'(LAST)) begin
									// final cell written: scroll
									idx_q   <= IW'(COLUMNS);
									wa_q    <= '0;
									scr_q   <= 1'b1;
									state_q <= S_COPY;
								end else begin
									cursor_q <= cursor_q + 1'b1;
									state_q  <= S_DONE;
								end
							end
							CMD_CLEAR: state_q <= S_FILL;
							CMD_SET: begin
								cursor_q <= pos_c;
								state_q  <= S_DONE;
							end
							CMD_READ: state_q <= S_READ;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_FILL: begin
					idx_q <= sum;
					if (idx_q == IW'(LAST)) begin
						cursor_q <= '0;
						state_q  <= S_DONE;
					end
				end
				S_ROWF: begin
					if (row_found) begin
						if (idx_q >= IW'(LRS)) begin
							// newline on the last row
							idx_q   <= IW'(COLUMNS);
							wa_q    <= '0;
							scr_q   <= 1'b1;
							state_q <= S_COPY;
						end else begin
							cursor_q <= sum[AW-1:0];
							state_q  <= S_DONE;
						end
					end else begin
						idx_q <= sum;
					end
				end
				S_COPY: begin
					if (idx_q == IW'(LAST)) begin
						state_q <= S_BLANK;
					end else begin
						idx_q <= sum;
					end
				end
				S_BLANK: begin
					if (!rd_pend_q && wa_q == AW'(LAST)) begin
						cursor_q <= AW'(LRS);
						state_q  <= S_DONE;
					end
				end
				S_READ: begin
					rd_chr_q <= ram_rdata[CHAR_W-1:0];
					rd_col_q <= ram_rdata[CELL_W-1:CHAR_W];
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	assign cur_ext        = PW'(cursor_q);
	assign res_valid      = (state_q == S_DONE);
	assign res.cursor     = cur_ext[POS_W-1:0];
	assign res.cell_char  = rd_chr_q;
	assign res.cell_color = rd_col_q;
	assign res.scrolled   = scr_q;

	`TCCS_ASSERT_ALWAYS(a_cursor_in_range, clk, arst_n, cursor_q <= AW'(LAST))
	`TCCS_ASSERT_IMPLIES(a_waddr_in_range, clk, arst_n, ram_we, ram_waddr <= AW'(LAST))
	`TCCS_ASSERT_IMPLIES(a_pend_in_scroll, clk, arst_n, rd_pend_q, state_q == S_COPY || state_q == S_BLANK)
	`TCCS_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != S_IDLE)
	`TCCS_ASSERT_IMPLIES(a_take_when_done, clk, arst_n, res_take, state_q == S_DONE)

endmodule

// ----- design/text_console_cursor_scroll.sv -----
// text console engine: screen store, cursor, scroll and clear sequencing
// depends on tccs_pkg, tccs_ctrl and tccs_ram
//
// usage
// - s_* carries one command item; m_* returns exactly one result item per command
// - cfg_we/cfg_wdata set the colour used for cells blanked by clear or scroll
// - one command at a time: s_tready is high only while the sequencer is idle
// - how each command is carried out:
//   write cell, set cursor, unused codes, plain append: any write or cursor update is made as the item is taken
//   read cell: one registered memory read
//   newline without scroll: the row search steps one row a cycle
//   scroll after the final cell, or after a newline that the row search finds on the last row:
//   the copy moves one cell a cycle, then the bottom row is blanked a cell a cycle
//   clear: one cell written a cycle
// - after reset the store is swept to blank cells with colour seven; s_tready
//   stays low during the sweep, configuration writes are taken
// - the result waits in an output register; a new item is taken while it
//   waits, but its own result is not finished until the register is free, so
//   a stalled m_tready holds the block after at most one further item
module text_console_cursor_scroll #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: command[2:0], char_code[10:3], color[18:11], position[29:19]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	// m_tdata: cursor[10:0], cell_char[18:11], cell_color[26:19], scrolled[27]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	import tccs_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	logic [CHAR_W-1:0] blank_color_q;
	logic              out_valid_q;
	res_t              out_res_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;
	logic              res_valid;
	logic              res_take;
	res_t              res;

	// blank colour register, written whenever the enable is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_color_q <= RESET_COLOR;
		end else if (cfg_we) begin
			blank_color_q <= cfg_wdata;
		end
	end

	tccs_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.command     (s_tdata[2:0]),
		.char_code   (s_tdata[10:3]),
		.color       (s_tdata[18:11]),
		.position    (s_tdata[29:19]),
		.blank_color (blank_color_q),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res)
	);

	// screen store: char in the low byte, colour in the high byte
	tccs_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result register: loads when empty or being emptied this cycle
	assign res_take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_res_q.scrolled, out_res_q.cell_color,
		out_res_q.cell_char, out_res_q.cursor};

endmodule
